// ----- rtl/thread_slot_round_robin_scheduler_defines.svh -----
// Assertion macros shared by the verification side of the thread slot scheduler.
// Depends on nothing; the asserting module must provide clk and arst_n.
`ifndef THREAD_SLOT_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define THREAD_SLOT_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSRR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSRR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tsrr_pkg.sv -----
// Package of the thread slot scheduler: codes, slot record and control structs.
// Depends on nothing; used by the table, the top level, the checker and the testbench.
package tsrr_pkg;

	localparam logic [2:0] OP_SPAWN_RUN = 3'd0;
	localparam logic [2:0] OP_SPAWN_SLP = 3'd1;
	localparam logic [2:0] OP_END       = 3'd2;
	localparam logic [2:0] OP_SET       = 3'd3;
	localparam logic [2:0] OP_SCHED     = 3'd4;

	localparam logic [1:0] TS_DEAD  = 2'd0;
	localparam logic [1:0] TS_RUN   = 2'd1;
	localparam logic [1:0] TS_SLEEP = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_NOID  = 2'd2;
	localparam logic [1:0] STS_NORUN = 2'd3;

	localparam logic signed [16:0] ID_NONE = 17'h1FFFF;

	typedef struct packed {
		logic [1:0]  state;
		logic [15:0] id;
		logic [16:0] parent;
	} tsrr_rec_t;

	localparam tsrr_rec_t REC_RESET = '{state: TS_DEAD, id: 16'd0, parent: ID_NONE};

	// Update request from the sequencer to the slot table.
	typedef struct packed {
		logic wr;
		logic clr;
	} tsrr_upd_t;

	// Registered read result of the slot table.
	typedef struct packed {
		logic      vld;
		tsrr_rec_t rec;
	} tsrr_rd_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_CUR_RD,
		FSM_CUR_WAIT,
		FSM_FINISH
	} tsrr_fsm_t;

endpackage

// ----- rtl/tsrr_ifs.sv -----
// Valid/ready channel interfaces for the request and response sides of the scheduler.
// Depends on nothing.
interface tsrr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [15:0] thread_id;
	logic [1:0]  new_state;

	modport source (output valid, output operation, output thread_id, output new_state,
		input ready);
	modport sink (input valid, input operation, input thread_id, input new_state,
		output ready);
endinterface

interface tsrr_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [3:0]         slot;
	logic signed [16:0] result_id;
	logic signed [16:0] parent_id;

	modport source (output valid, output status, output slot, output result_id,
		output parent_id, input ready);
	modport sink (input valid, input status, input slot, input result_id,
		input parent_id, output ready);
endinterface

// ----- rtl/tsrr_table.sv -----
// Slot table of the scheduler: one-write, one-read record memory with per-slot valid bits.
// Depends on tsrr_pkg.
module tsrr_table
	import tsrr_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
	input  tsrr_upd_t                     upd,
	input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
	input  tsrr_rec_t                     wr_rec,
	output tsrr_rd_t                      rd
);

	tsrr_rec_t               mem [SLOT_COUNT];
	tsrr_rec_t               rec_s1;
	logic [SLOT_COUNT-1:0]   vld_q;
	logic                    vld_s1;

	always_ff @(posedge clk) begin
		if (upd.wr) begin
			mem[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rec_s1 <= mem[rd_addr];
		end
	end

	// A slot that was never written, or was ended, reads as the reset record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (upd.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end else if (upd.clr) begin
				vld_q[wr_addr] <= 1'b0;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd.vld = vld_s1;
	assign rd.rec = vld_s1 ? rec_s1 : REC_RESET;

endmodule

// ----- rtl/thread_slot_round_robin_scheduler.sv -----
// Top level of the thread slot round-robin scheduler: sequencer, scan logic and result register.
// Depends on tsrr_pkg, tsrr_ifs (tsrr_req_if, tsrr_rsp_if) and tsrr_table.
//
// The block keeps a table of SLOT_COUNT thread slots (state, 16-bit id, parent id), the current
// slot and a wrapping 16-bit id counter, and answers every request transfer with exactly one
// response transfer. Spawn takes the lowest dead slot, end and set-state look up the lowest slot
// holding the given id, and schedule walks the slots after the current one in circular order for
// a runnable one. All of these searches go through the table's single read port, one slot per
// cycle. The block accepts a new request while the previous response still waits in the output
// register; it only holds back the final step of the new request until that response has been
// taken. Failed lookups and a full table report slot 0 with ids of -1, and a schedule with no
// other runnable slot reports the unchanged current slot with the no-runnable status. After
// reset every slot is dead and holds no id; no clearing pass is needed because the table
// carries a valid bit per slot.
module thread_slot_round_robin_scheduler
	import tsrr_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	tsrr_req_if.sink    req,
	tsrr_rsp_if.source  rsp
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
	localparam logic [CW-1:0] LIM_ALL   = CW'(SLOT_COUNT);
	localparam logic [CW-1:0] LIM_SCHED = CW'(SLOT_COUNT - 1);

	tsrr_fsm_t state_q, state_d;

	// Latched request.
	logic [2:0]    op_q;
	logic [15:0]   tid_q;
	logic [1:0]    ns_q;

	// Scan control and the read pipeline of the table.
	logic [SW-1:0] scan_addr_q;
	logic [CW-1:0] issued_q;
	logic [CW-1:0] limit_q;
	logic          pend_s1;
	logic [SW-1:0] rd_idx_s1;

	// Result under construction and the update to apply when it is posted.
	logic [1:0]    st_q;
	logic [SW-1:0] res_idx_q;
	logic [16:0]   res_id_q;
	logic [16:0]   res_par_q;
	tsrr_rec_t     wr_rec_q;
	logic          wr_pend_q;
	logic          clr_pend_q;
	logic          cur_upd_q;
	logic          id_inc_q;

	logic [SW-1:0] cur_slot_q;
	logic [15:0]   next_id_q;

	// Output register.
	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic [3:0]    rsp_slot_q;
	logic [16:0]   rsp_id_q;
	logic [16:0]   rsp_par_q;

	logic          accept;
	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic          scan_issue;
	logic          hit;
	logic          miss;
	logic          cur_done;
	logic          fin;
	logic          match;
	logic          is_spawn;
	logic [16:0]   rd_id_of;
	logic [SW+3:0] slot_ext;
	tsrr_rd_t      rd;
	tsrr_upd_t     upd;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] a);
		slot_inc = (a == LAST_SLOT) ? '0 : a + 1'b1;
	endfunction

	assign is_spawn = (op_q == OP_SPAWN_RUN) || (op_q == OP_SPAWN_SLP);
	assign rd_id_of = rd.vld ? {1'b0, rd.rec.id} : ID_NONE;
	assign accept   = req.valid && req.ready;

	// What the scan is looking for depends on the operation.
	always_comb begin
		if (is_spawn) begin
			match = (rd.rec.state == TS_DEAD);
		end else if (op_q == OP_SCHED) begin
			match = (rd.rec.state == TS_RUN);
		end else begin
			match = rd.vld && (rd.rec.id == tid_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: a scan issues one table read per cycle and judges the data that returns in the
	// next cycle; the cycle of a hit issues no further read, so none is left in flight.
	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = scan_addr_q;
		scan_issue = 1'b0;
		hit        = 1'b0;
		miss       = 1'b0;
		cur_done   = 1'b0;
		fin        = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.operation inside {OP_SPAWN_RUN, OP_SPAWN_SLP, OP_END, OP_SET,
						OP_SCHED}) begin
						state_d = FSM_SCAN;
					end else begin
						state_d = FSM_CUR_RD;
					end
				end
			end
			FSM_SCAN: begin
				if (pend_s1 && match) begin
					hit     = 1'b1;
					state_d = is_spawn ? FSM_CUR_RD : FSM_FINISH;
				end else if (!pend_s1 && (issued_q == limit_q)) begin
					miss    = 1'b1;
					state_d = (op_q == OP_SCHED) ? FSM_CUR_RD : FSM_FINISH;
				end else if (issued_q != limit_q) begin
					rd_en      = 1'b1;
					scan_issue = 1'b1;
				end
			end
			FSM_CUR_RD: begin
				rd_en   = 1'b1;
				rd_addr = cur_slot_q;
				state_d = FSM_CUR_WAIT;
			end
			FSM_CUR_WAIT: begin
				cur_done = 1'b1;
				state_d  = FSM_FINISH;
			end
			FSM_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					fin     = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			wr_pend_q   <= 1'b0;
			clr_pend_q  <= 1'b0;
			cur_upd_q   <= 1'b0;
			id_inc_q    <= 1'b0;
			cur_slot_q  <= '0;
			next_id_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (hit) begin
				id_inc_q   <= is_spawn;
				wr_pend_q  <= is_spawn || ((op_q == OP_SET) && (ns_q <= TS_SLEEP));
				clr_pend_q <= (op_q == OP_END);
				cur_upd_q  <= (op_q == OP_SCHED);
			end
			if (fin) begin
				wr_pend_q   <= 1'b0;
				clr_pend_q  <= 1'b0;
				cur_upd_q   <= 1'b0;
				id_inc_q    <= 1'b0;
				rsp_valid_q <= 1'b1;
				if (cur_upd_q) begin
					cur_slot_q <= res_idx_q;
				end
				if (id_inc_q) begin
					next_id_q <= next_id_q + 1'b1;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign slot_ext = {4'b0000, res_idx_q};

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (accept) begin
			op_q        <= req.operation;
			tid_q       <= req.thread_id;
			ns_q        <= req.new_state;
			scan_addr_q <= (req.operation == OP_SCHED) ? slot_inc(cur_slot_q) : '0;
			issued_q    <= '0;
			limit_q     <= (req.operation == OP_SCHED) ? LIM_SCHED : LIM_ALL;
			st_q        <= STS_OK;
		end
		if (scan_issue) begin
			scan_addr_q <= slot_inc(scan_addr_q);
			issued_q    <= issued_q + 1'b1;
		end
		if (hit) begin
			res_idx_q <= rd_idx_s1;
			if (is_spawn) begin
				wr_rec_q.state <= (op_q == OP_SPAWN_RUN) ? TS_RUN : TS_SLEEP;
				wr_rec_q.id    <= next_id_q;
				res_id_q       <= {1'b0, next_id_q};
			end else begin
				wr_rec_q.state  <= ns_q;
				wr_rec_q.id     <= rd.rec.id;
				wr_rec_q.parent <= rd.rec.parent;
				res_id_q        <= rd_id_of;
				res_par_q       <= rd.rec.parent;
			end
		end
		if (miss) begin
			res_idx_q <= '0;
			res_id_q  <= ID_NONE;
			res_par_q <= ID_NONE;
			if (is_spawn) begin
				st_q <= STS_FULL;
			end else if (op_q == OP_SCHED) begin
				st_q <= STS_NORUN;
			end else begin
				st_q <= STS_NOID;
			end
		end
		if (cur_done) begin
			if (is_spawn) begin
				// The new thread's parent is whatever id the current slot holds.
				wr_rec_q.parent <= rd_id_of;
				res_par_q       <= rd_id_of;
			end else begin
				res_idx_q <= rd_idx_s1;
				res_id_q  <= rd_id_of;
				res_par_q <= rd.rec.parent;
			end
		end
		if (fin) begin
			rsp_status_q <= st_q;
			rsp_slot_q   <= slot_ext[3:0];
			rsp_id_q     <= res_id_q;
			rsp_par_q    <= res_par_q;
		end
	end

	assign upd.wr  = fin && wr_pend_q;
	assign upd.clr = fin && clr_pend_q;

	tsrr_table #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.upd     (upd),
		.wr_addr (res_idx_q),
		.wr_rec  (wr_rec_q),
		.rd      (rd)
	);

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.slot      = rsp_slot_q;
	assign rsp.result_id = rsp_id_q;
	assign rsp.parent_id = rsp_par_q;

endmodule

// ----- rtl/tsrr_checker.sv -----
// Port-level assertions for the thread slot scheduler and the bind that attaches them.
// Depends on tsrr_pkg, thread_slot_round_robin_scheduler_defines.svh and the top level.
`include "thread_slot_round_robin_scheduler_defines.svh"

module tsrr_checker
	import tsrr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [1:0]         rsp_status,
	input logic [3:0]         rsp_slot,
	input logic signed [16:0] rsp_result_id,
	input logic signed [16:0] rsp_parent_id
);

	logic [39:0] rsp_payload;
	logic        rsp_stall;
	logic        req_xfer;
	logic        rsp_failed;
	logic        rsp_blank;

	assign rsp_payload = {rsp_status, rsp_slot, rsp_result_id, rsp_parent_id};
	assign rsp_stall   = rsp_valid && !rsp_ready;
	assign req_xfer    = req_valid && req_ready;
	assign rsp_failed  = rsp_valid && (rsp_status inside {STS_FULL, STS_NOID});
	assign rsp_blank   = (rsp_slot == 4'd0) && (rsp_result_id == ID_NONE)
		&& (rsp_parent_id == ID_NONE);

	// A stalled response keeps its contents.
	`TSRR_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "held response changed")

	// Only one request is in work at a time.
	`TSRR_ASSERT_NXT(a_one_item, req_xfer, !req_ready, "request taken while another is in work")

	// Every request needs at least a table read before its response can appear.
	`TSRR_ASSERT_NXT(a_no_instant_rsp, req_xfer, !$rose(rsp_valid), "response right after request")

	// Failed spawns and lookups report slot 0 and no ids.
	`TSRR_ASSERT_IMP(a_fail_fields, rsp_failed, rsp_blank, "failure response carries slot data")

endmodule

bind thread_slot_round_robin_scheduler tsrr_checker u_tsrr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_slot      (rsp.slot),
	.rsp_result_id (rsp.result_id),
	.rsp_parent_id (rsp.parent_id)
);

// ----- test/tb.sv -----
// Self-checking testbench for the thread slot round-robin scheduler: directed and random
// spawn, end, set-state and schedule requests checked against a cycle-free predictor.
// Depends on tsrr_pkg, the tsrr_req_if and tsrr_rsp_if interfaces and the scheduler top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tsrr_pkg::*;

	localparam int SLOTS = 16;
	localparam int RANDOM_ITEMS = 700;
	localparam int QUIET_ITEMS = 80;
	localparam int HOLD_CYCLES = 300;

	// One response as the scheduler reports it.
	typedef struct {
		logic [1:0]         status;
		logic [3:0]         slot;
		logic signed [16:0] result_id;
		logic signed [16:0] parent_id;
	} thread_result_t;

	// The scoreboard keeps its own copy of the slot table. Every accepted request is applied
	// to that copy at once, and the response it must produce is queued in request order.
	class thread_table_scoreboard;
		logic [1:0]         slot_st[SLOTS];
		logic [15:0]        slot_tid[SLOTS];
		bit                 slot_tid_ok[SLOTS];
		logic signed [16:0] slot_par[SLOTS];
		logic [3:0]         cur_slot;
		logic [15:0]        id_counter;
		thread_result_t     awaited[$];
		int                 failures;

		function new();
			for (int s = 0; s < SLOTS; s++) begin
				slot_st[s] = TS_DEAD;
				slot_tid[s] = '0;
				slot_tid_ok[s] = 1'b0;
				slot_par[s] = ID_NONE;
			end
			cur_slot = '0;
			id_counter = '0;
			failures = 0;
		endfunction

		function logic signed [16:0] id_of(int s);
			return slot_tid_ok[s] ? $signed({1'b0, slot_tid[s]}) : ID_NONE;
		endfunction

		function int find_slot(logic [15:0] tid);
			for (int s = 0; s < SLOTS; s++)
				if (slot_tid_ok[s] && slot_tid[s] == tid)
					return s;
			return -1;
		endfunction

		function void push_slot(logic [1:0] status, int s);
			thread_result_t r;
			r.status = status;
			r.slot = s[3:0];
			r.result_id = id_of(s);
			r.parent_id = slot_par[s];
			awaited.push_back(r);
		endfunction

		function void push_none(logic [1:0] status);
			thread_result_t r;
			r.status = status;
			r.slot = '0;
			r.result_id = ID_NONE;
			r.parent_id = ID_NONE;
			awaited.push_back(r);
		endfunction

		function void note_request(logic [2:0] op, logic [15:0] tid, logic [1:0] ns);
			int s;
			logic [3:0] c;
			s = -1;
			case (op)
				OP_SPAWN_RUN, OP_SPAWN_SLP: begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (slot_st[i] == TS_DEAD)
							s = i;
					if (s < 0) begin
						push_none(STS_FULL);
					end else begin
						slot_par[s] = id_of(cur_slot);
						slot_st[s] = (op == OP_SPAWN_RUN) ? TS_RUN : TS_SLEEP;
						slot_tid[s] = id_counter;
						slot_tid_ok[s] = 1'b1;
						id_counter = id_counter + 16'd1;
						push_slot(STS_OK, s);
					end
				end
				OP_END, OP_SET: begin
					s = find_slot(tid);
					if (s < 0) begin
						push_none(STS_NOID);
					end else begin
						push_slot(STS_OK, s);
						if (op == OP_END) begin
							slot_st[s] = TS_DEAD;
							slot_tid[s] = '0;
							slot_tid_ok[s] = 1'b0;
							slot_par[s] = ID_NONE;
						end else if (ns <= TS_SLEEP) begin
							slot_st[s] = ns;
						end
					end
				end
				OP_SCHED: begin
					for (int i = 1; i < SLOTS && s < 0; i++) begin
						c = cur_slot + i[3:0];
						if (slot_st[c] == TS_RUN)
							s = c;
					end
					if (s < 0) begin
						push_slot(STS_NORUN, cur_slot);
					end else begin
						cur_slot = s[3:0];
						push_slot(STS_OK, s);
					end
				end
				default: begin
					push_slot(STS_OK, cur_slot);
				end
			endcase
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			failures++;
		endtask

		task check_result(thread_result_t got);
			thread_result_t exp_r;
			if (awaited.size() == 0) begin
				report($sformatf("response status %0d slot %0d with nothing outstanding",
					got.status, got.slot));
			end else begin
				exp_r = awaited.pop_front();
				if (got.status !== exp_r.status)
					report($sformatf("status %0d, predicted %0d", got.status, exp_r.status));
				if (got.slot !== exp_r.slot)
					report($sformatf("slot %0d, predicted %0d", got.slot, exp_r.slot));
				if (got.result_id !== exp_r.result_id)
					report($sformatf("result_id %0d, predicted %0d",
						got.result_id, exp_r.result_id));
				if (got.parent_id !== exp_r.parent_id)
					report($sformatf("parent_id %0d, predicted %0d",
						got.parent_id, exp_r.parent_id));
			end
		endtask

		function int pending();
			return awaited.size();
		endfunction

		// Mostly an id that some slot holds right now, sometimes any 16-bit value.
		function logic [15:0] pick_id();
			logic [15:0] live[$];
			for (int s = 0; s < SLOTS; s++)
				if (slot_tid_ok[s])
					live.push_back(slot_tid[s]);
			if (live.size() > 0 && $urandom_range(0, 4) != 0)
				return live[$urandom_range(0, live.size() - 1)];
			return 16'($urandom);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   hold_rsp;

	tsrr_req_if req_ch();
	tsrr_rsp_if rsp_ch();

	thread_table_scoreboard sb = new();

	thread_slot_round_robin_scheduler #(.SLOT_COUNT(SLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Safety net: the slowest legal run is far below this. Each request costs at most a full
	// scan of the block plus one sender gap and one receiver stall, and there are well under a
	// thousand of them, plus one long receiver hold.
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Both monitors sample at the rising edge, before any nonblocking update of that edge lands,
	// so a request and a response transfer are each seen exactly once.
	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.operation, req_ch.thread_id, req_ch.new_state);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result('{rsp_ch.status, rsp_ch.slot, rsp_ch.result_id, rsp_ch.parent_id});
	end

	// Response side. It alternates random stretches of ready with random stall bursts. On
	// request it holds ready low for a long, fixed stretch so that the output register and the
	// request in flight both back up and the block stops taking requests.
	// Near the end it stays ready all the time.
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Offers one request and returns at the edge where it was transferred. An optional idle
	// burst comes first; valid is only lowered when such a burst actually happens, so back to
	// back requests keep valid high without a glitch.
	task automatic send_request(input logic [2:0] op, input logic [15:0] tid,
		input logic [1:0] ns);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.thread_id <= tid;
		req_ch.new_state <= ns;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Stops offering and waits until every outstanding response has been transferred.
	task automatic drain_responses();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// One random request. The mix swings between a spawn-heavy phase, which fills the table up
	// to the point where spawns report it full, and an end-heavy phase, which empties it again.
	// End and set-state mostly aim at live ids so that lookups hit; a few operations are the
	// unused codes five to seven.
	task automatic random_request(input int n);
		int pick;
		int spawn_w;
		int end_w;
		logic [2:0] op;
		logic [15:0] tid;
		pick = $urandom_range(0, 99);
		spawn_w = ((n / 60) % 2 == 0) ? 45 : 15;
		end_w = ((n / 60) % 2 == 0) ? 10 : 35;
		tid = 16'($urandom);
		if (pick < spawn_w) begin
			op = ($urandom_range(0, 1) == 0) ? OP_SPAWN_RUN : OP_SPAWN_SLP;
		end else if (pick < spawn_w + end_w) begin
			op = OP_END;
			tid = sb.pick_id();
		end else if (pick < 75) begin
			op = OP_SET;
			tid = sb.pick_id();
		end else if (pick < 95) begin
			op = OP_SCHED;
		end else begin
			op = 3'($urandom_range(5, 7));
		end
		send_request(op, tid, 2'($urandom_range(0, 3)));
	endtask

	initial begin
		arst_n <= 1'b0;
		quiet = 1'b0;
		hold_rsp = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.operation <= OP_SPAWN_RUN;
		req_ch.thread_id <= '0;
		req_ch.new_state <= TS_DEAD;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With an empty table a schedule finds nothing runnable, lookups fail,
		// and the unused codes just report the current slot.
		send_request(OP_SCHED, 16'h0000, TS_DEAD);
		send_request(3'd5, 16'hFFFF, 2'd3);
		send_request(3'd6, 16'h0000, TS_RUN);
		send_request(3'd7, 16'hAAAA, TS_SLEEP);
		send_request(OP_END, 16'h0000, TS_DEAD);
		send_request(OP_SET, 16'hFFFF, TS_RUN);
		// First thread has no parent, the second gets id 0 as its parent.
		send_request(OP_SPAWN_RUN, 16'h5555, 2'd3);
		send_request(OP_SPAWN_SLP, 16'h0000, TS_DEAD);
		// Only slot 0 is runnable, and it is current: no other runnable slot.
		send_request(OP_SCHED, 16'h0000, TS_DEAD);
		send_request(OP_SET, 16'h0001, TS_RUN);
		send_request(OP_SCHED, 16'h0000, TS_DEAD);
		send_request(OP_SPAWN_RUN, 16'h0000, TS_DEAD);
		// A new state of three still reports ok but leaves the slot as it was.
		send_request(OP_SET, 16'h0002, 2'd3);
		send_request(OP_SCHED, 16'h0000, TS_DEAD);
		send_request(OP_SCHED, 16'h0000, TS_DEAD);
		// A slot set to dead keeps its id: it can still be found, and ended.
		send_request(OP_SET, 16'h0000, TS_DEAD);
		send_request(OP_SET, 16'h0000, TS_SLEEP);
		send_request(OP_SET, 16'h0000, TS_DEAD);
		send_request(OP_END, 16'h0000, TS_RUN);
		send_request(OP_END, 16'h0000, TS_RUN);
		send_request(OP_SPAWN_SLP, 16'hFFFF, TS_SLEEP);
		send_request(OP_END, 16'h0001, TS_DEAD);
		send_request(OP_SCHED, 16'hFFFF, 2'd3);
		drain_responses();

		// Random part, with one long receiver hold and one full pause of the sender.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 200)
				hold_rsp = 1'b1;
			if (n == 400)
				drain_responses();
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			random_request(n);
		end

		drain_responses();
		repeat (40) @(posedge clk);
		if (sb.failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
